/* src/char_lcd_nibble_writer_core_assert.svh */
// assertion macros for the character lcd nibble writer
// used by the sequencer module, needs a clk and rst in scope
`ifndef CHAR_LCD_NIBBLE_WRITER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define CLNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/clcd_nw_pkg.sv */
// shared types, constants and the cyrillic font map for the lcd nibble writer
// no dependencies
package clcd_nw_pkg;

  localparam int unsigned HoldW = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPulse   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDataWt  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCmdWt   = 2'd2;

  localparam logic [HoldW-1:0] PulseRst   = 16'd100;
  localparam logic [HoldW-1:0] DataWtRst  = 16'd100;
  localparam logic [HoldW-1:0] CmdWtRst   = 16'd2000;

  // codes above this one are candidates for remapping
  localparam logic [7:0] MapFloor = 8'hA0;
  localparam logic [7:0] YoUpper  = 8'hA8;
  localparam logic [7:0] YoLower  = 8'hB8;
  localparam logic [7:0] YoRom    = 8'hA2;

  // font rom codes for windows-1251 0xc0..0xff
  localparam logic [7:0] CYR_MAP [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // one queued byte write
  typedef struct packed {
    logic [7:0] code;
    logic       mode;
  } item_t;

  // live configuration
  typedef struct packed {
    logic [HoldW-1:0] pulse;
    logic [HoldW-1:0] data_wait;
    logic [HoldW-1:0] cmd_wait;
  } cfg_t;

  // sequencer phases, one-hot
  typedef enum logic [5:0] {
    PH0 = 6'b000001,
    PH1 = 6'b000010,
    PH2 = 6'b000100,
    PH3 = 6'b001000,
    PH4 = 6'b010000,
    PH5 = 6'b100000
  } phase_t;

  // windows-1251 to font rom, only applied to data codes above 0xa0
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'hC0) begin
      r = CYR_MAP[c[5:0]];
    end else if (c == YoUpper || c == YoLower) begin
      r = YoRom;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

/* src/char_lcd_nibble_writer_core.sv */
// A byte's phases pass the front-end holding register, the queue and the output register.
// Throughput: one phase per cycle unless m_tready stalls; the back end gives six per byte.
// The front end keeps accepting while the queue has room, so bytes follow back to back.
// Reset (synchronous, active high) empties the queue and output register, rewinds the
// sequencer and loads the timing registers with 100, 100 and 2000 ticks.
module char_lcd_nibble_writer_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // value[7:0]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bus_nibble[3:0], enable_level[4], hold_ticks[20:5]
  output logic        m_tuser,   // register_select
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  clcd_nw_pkg::cfg_t  cfg;
  clcd_nw_pkg::item_t push_item;
  clcd_nw_pkg::item_t head;
  logic               push;
  logic               q_ready;
  logic               q_valid;
  logic               pop;

  // timing registers, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse     <= clcd_nw_pkg::PulseRst;
      cfg.data_wait <= clcd_nw_pkg::DataWtRst;
      cfg.cmd_wait  <= clcd_nw_pkg::CmdWtRst;
    end else if (cfg_we) begin
      case (cfg_index)
        clcd_nw_pkg::CfgPulse:  cfg.pulse     <= cfg_data;
        clcd_nw_pkg::CfgDataWt: cfg.data_wait <= cfg_data;
        clcd_nw_pkg::CfgCmdWt:  cfg.cmd_wait  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request intake and remap
  clcd_nw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  // decoupling queue
  clcd_nw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // phase sequencer
  clcd_nw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/clcd_nw_front.sv */
// front end: accepts byte requests, remaps data codes, registers them
// depends on clcd_nw_pkg
module clcd_nw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,  // value[7:0]
  input  logic                s_tuser,  // mode
  output logic                push,
  output clcd_nw_pkg::item_t  push_item,
  input  logic                q_ready
);

  logic               hold_valid;
  clcd_nw_pkg::item_t hold_item;
  logic               accept;
  logic [7:0]         mapped;

  // remap only data bytes above 0xa0
  always_comb begin
    if (s_tuser && (s_tdata > clcd_nw_pkg::MapFloor)) begin
      mapped = clcd_nw_pkg::map_char(s_tdata);
    end else begin
      mapped = s_tdata;
    end
  end

  assign push     = hold_valid && q_ready;
  assign s_tready = !hold_valid || push;
  assign accept   = s_tvalid && s_tready;
  assign push_item = hold_item;

  // holding register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  // holding register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item.code <= mapped;
      hold_item.mode <= s_tuser;
    end
  end

endmodule

/* src/clcd_nw_queue.sv */
// short queue between front end and phase sequencer
// depends on clcd_nw_pkg
module clcd_nw_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clcd_nw_pkg::item_t  push_item,
  output logic                q_ready,
  input  logic                pop,
  output logic                q_valid,
  output clcd_nw_pkg::item_t  head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  clcd_nw_pkg::item_t mem [DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               do_push;
  logic               do_pop;

  assign q_ready = (count != CntFull);
  assign q_valid = (count != '0);
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;
  assign head    = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/clcd_nw_back.sv */
// back end: steps each queued byte through six pin phases into an output register
// depends on clcd_nw_pkg and char_lcd_nibble_writer_core_assert.svh
`include "char_lcd_nibble_writer_core_assert.svh"

module clcd_nw_back (
  input  logic                clk,
  input  logic                rst,
  input  clcd_nw_pkg::cfg_t   cfg,
  input  logic                q_valid,
  input  clcd_nw_pkg::item_t  head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,  // bus_nibble[3:0], enable_level[4], hold_ticks[20:5]
  output logic                m_tuser,  // register_select
  output logic                m_tlast
);

  clcd_nw_pkg::phase_t      phase;
  clcd_nw_pkg::phase_t      phase_next;
  logic                     emit;
  logic [3:0]               nib;
  logic                     en;
  logic [clcd_nw_pkg::HoldW-1:0] hold;
  logic                     is_last;
  logic [3:0]               out_nib;
  logic                     out_en;
  logic [clcd_nw_pkg::HoldW-1:0] out_hold;

  assign emit = q_valid && (!m_tvalid || m_tready);
  assign pop  = emit && (phase == clcd_nw_pkg::PH5);

  // phase decode
  always_comb begin
    nib        = head.code[3:0];
    en         = 1'b0;
    hold       = cfg.pulse;
    is_last    = 1'b0;
    phase_next = clcd_nw_pkg::PH0;
    case (phase)
      clcd_nw_pkg::PH0: begin
        nib        = head.code[7:4];
        hold       = '0;
        phase_next = clcd_nw_pkg::PH1;
      end
      clcd_nw_pkg::PH1: begin
        nib        = head.code[7:4];
        en         = 1'b1;
        phase_next = clcd_nw_pkg::PH2;
      end
      clcd_nw_pkg::PH2: begin
        nib        = head.code[7:4];
        phase_next = clcd_nw_pkg::PH3;
      end
      clcd_nw_pkg::PH3: begin
        hold       = '0;
        phase_next = clcd_nw_pkg::PH4;
      end
      clcd_nw_pkg::PH4: begin
        en         = 1'b1;
        phase_next = clcd_nw_pkg::PH5;
      end
      clcd_nw_pkg::PH5: begin
        hold       = head.mode ? cfg.data_wait : cfg.cmd_wait;
        is_last    = 1'b1;
        phase_next = clcd_nw_pkg::PH0;
      end
      default: begin
        phase_next = clcd_nw_pkg::PH0;
      end
    endcase
  end

  // phase register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= clcd_nw_pkg::PH0;
      m_tvalid <= 1'b0;
    end else if (emit) begin
      phase    <= phase_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_nib  <= nib;
      out_en   <= en;
      out_hold <= hold;
      m_tuser  <= head.mode;
      m_tlast  <= is_last;
    end
  end

  assign m_tdata = {3'b000, out_hold, out_en, out_nib};

  // sequencer checks
  `CLNW_ASSERT_NOW(a_pop_on_final, pop, emit && (phase == clcd_nw_pkg::PH5), "pop off final phase")
  `CLNW_ASSERT_NOW(a_no_emit_empty, !q_valid, !emit, "phase emitted with empty queue")
  `CLNW_ASSERT_NEXT(a_strobe_then_fall, emit && (phase == clcd_nw_pkg::PH1), phase == clcd_nw_pkg::PH2, "enable high not followed by fall")
  `CLNW_ASSERT_NOW(a_last_strobe_low, m_tvalid && m_tlast, !out_en, "enable high on final phase")

endmodule

/* bench/char_lcd_nibble_writer_tb_pkg.sv */
`timescale 1ns / 100ps
// shared codes for the character lcd nibble writer bench
// no dependencies
package char_lcd_nibble_writer_tb_pkg;

  // request selector carried on s_tuser
  typedef enum logic {
    ModeCommand = 1'b0,
    ModeData    = 1'b1
  } lcd_mode_t;

endpackage

/* bench/char_lcd_nibble_writer_checker.sv */
`timescale 1ns / 100ps
// pin phase checker for the character lcd nibble writer: predicts six phases per request
// needs clcd_nw_pkg and char_lcd_nibble_writer_tb_pkg
module char_lcd_nibble_writer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // value[7:0]
  input  logic        s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // bus_nibble[3:0], enable_level[4], hold_ticks[20:5]
  input  logic        m_tuser,   // register_select
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned pending_phases
);

  // font rom codes for windows-1251 0xc0..0xff
  localparam logic [7:0] Cp1251Rom [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  typedef struct packed {
    logic [3:0]                    nibble;
    logic                          rs;
    logic                          e_level;
    logic [clcd_nw_pkg::HoldW-1:0] hold;
    logic                          last;
  } pin_phase_t;

  pin_phase_t        phase_q[$];
  clcd_nw_pkg::cfg_t timing;

  // code that reaches the bus: only data above 0xa0 goes through the font table
  function automatic logic [7:0] rom_code(
    input logic [7:0] value,
    input char_lcd_nibble_writer_tb_pkg::lcd_mode_t mode
  );
    logic [7:0] code;
    code = value;
    if (mode == char_lcd_nibble_writer_tb_pkg::ModeData && value > 8'hA0) begin
      if (value >= 8'hC0) begin
        code = Cp1251Rom[value[5:0]];
      end else if (value == 8'hA8 || value == 8'hB8) begin
        code = 8'hA2;
      end
    end
    return code;
  endfunction

  // six pin phases of one byte write, high nibble first
  task automatic queue_byte(input logic [7:0] value,
                            input char_lcd_nibble_writer_tb_pkg::lcd_mode_t mode);
    logic [7:0]                    code;
    logic [clcd_nw_pkg::HoldW-1:0] final_hold;
    code = rom_code(value, mode);
    final_hold = (mode == char_lcd_nibble_writer_tb_pkg::ModeData) ?
                 timing.data_wait : timing.cmd_wait;
    phase_q.push_back(pin_phase_t'{code[7:4], mode, 1'b0, '0, 1'b0});
    phase_q.push_back(pin_phase_t'{code[7:4], mode, 1'b1, timing.pulse, 1'b0});
    phase_q.push_back(pin_phase_t'{code[7:4], mode, 1'b0, timing.pulse, 1'b0});
    phase_q.push_back(pin_phase_t'{code[3:0], mode, 1'b0, '0, 1'b0});
    phase_q.push_back(pin_phase_t'{code[3:0], mode, 1'b1, timing.pulse, 1'b0});
    phase_q.push_back(pin_phase_t'{code[3:0], mode, 1'b0, final_hold, 1'b1});
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // track register writes, predict on each request, compare each phase
  always @(posedge clk) begin : watch
    pin_phase_t want;
    if (rst) begin
      phase_q.delete();
      timing <= '{clcd_nw_pkg::PulseRst, clcd_nw_pkg::DataWtRst,
                  clcd_nw_pkg::CmdWtRst};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clcd_nw_pkg::CfgPulse:  timing.pulse <= cfg_data;
          clcd_nw_pkg::CfgDataWt: timing.data_wait <= cfg_data;
          clcd_nw_pkg::CfgCmdWt:  timing.cmd_wait <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        queue_byte(s_tdata, char_lcd_nibble_writer_tb_pkg::lcd_mode_t'(s_tuser));
      if (m_tvalid && m_tready) begin
        if (phase_q.size() == 0) begin
          $display("%0t: phase expected none actual tdata %h tuser %b tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = phase_q.pop_front();
          compare_field("bus_nibble", want.nibble, m_tdata[3:0]);
          compare_field("enable_level", want.e_level, m_tdata[4]);
          compare_field("hold_ticks", want.hold, m_tdata[20:5]);
          compare_field("register_select", want.rs, m_tuser);
          compare_field("last", want.last, m_tlast);
        end
      end
    end
    pending_phases = phase_q.size();
  end

endmodule

/* bench/char_lcd_nibble_writer_core_tb.sv */
`timescale 1ns / 100ps
// top of the character lcd nibble writer bench: clock, reset, requests, timing writes, verdict
// needs clcd_nw_pkg, char_lcd_nibble_writer_tb_pkg, the checker and the core
module char_lcd_nibble_writer_core_tb;

  localparam logic [clcd_nw_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned StallMax      = 14;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned Rounds        = 8;
  localparam int unsigned RoundItems    = 38;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  bit          quiet_source = 1'b0;
  bit          quiet_sink = 1'b0;
  int unsigned sink_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches;
  int unsigned pending_phases;

  char_lcd_nibble_writer_core uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  char_lcd_nibble_writer_checker phase_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .pending_phases
  );

  always #1 clk = ~clk;

  // phase sink: fresh stall after every accepted phase
  always @(posedge clk) begin : sink_pace
    int unsigned stall;
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall <= 0;
    end else if (m_tready) begin
      if (m_tvalid) begin
        stall = quiet_sink ? 0 : $urandom_range(0, StallMax);
        if (stall != 0) begin
          m_tready <= 1'b0;
          sink_stall <= stall - 1;
        end
      end
    end else if (sink_stall == 0) begin
      m_tready <= 1'b1;
    end else begin
      sink_stall <= sink_stall - 1;
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("** char_lcd_nibble_writer_core: FAILED **");
        $finish;
      end
    end
  end

  // one request, after a random gap unless the source is quiet; returns at the accepting edge
  task automatic send_request(input logic [7:0] value,
                              input char_lcd_nibble_writer_tb_pkg::lcd_mode_t mode);
    int unsigned gap;
    gap = quiet_source ? 0 : $urandom_range(0, StallMax);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= mode;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // stop requests and let every predicted phase drain
  task automatic wait_idle;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_phases != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [clcd_nw_pkg::CfgIdxW-1:0] index,
                           input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // new timing set, written while the core is idle
  task automatic write_timing(input logic [15:0] pulse, input logic [15:0] data_wait,
                              input logic [15:0] cmd_wait);
    wait_idle();
    write_reg(clcd_nw_pkg::CfgPulse, pulse);
    write_reg(clcd_nw_pkg::CfgDataWt, data_wait);
    write_reg(clcd_nw_pkg::CfgCmdWt, cmd_wait);
    write_reg(CfgUnused, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // half the codes drawn from 0xa0..0xff, the rest from the full range
  function automatic logic [7:0] pick_code;
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'hA0, 8'hFF)) : 8'($urandom);
  endfunction

  initial begin : stimulus
    logic [15:0] pulse, data_wait, cmd_wait;
    int unsigned r, i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed bytes under the reset timing
    send_request(8'h00, char_lcd_nibble_writer_tb_pkg::ModeCommand);
    send_request(8'hFF, char_lcd_nibble_writer_tb_pkg::ModeCommand);
    // command above 0xa0 stays unmapped
    send_request(8'hA1, char_lcd_nibble_writer_tb_pkg::ModeCommand);
    send_request(8'hC0, char_lcd_nibble_writer_tb_pkg::ModeCommand);
    send_request(8'h28, char_lcd_nibble_writer_tb_pkg::ModeCommand);
    send_request(8'h00, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'hFF, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'hA0, char_lcd_nibble_writer_tb_pkg::ModeData);  // boundary, not remapped
    send_request(8'hA1, char_lcd_nibble_writer_tb_pkg::ModeData);  // not in the table
    send_request(8'hA8, char_lcd_nibble_writer_tb_pkg::ModeData);  // capital yo
    send_request(8'hB8, char_lcd_nibble_writer_tb_pkg::ModeData);  // small yo
    send_request(8'hBF, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'hC0, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'hDF, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'hE0, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'h41, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'h7F, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'h80, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'hB9, char_lcd_nibble_writer_tb_pkg::ModeData);
    send_request(8'h01, char_lcd_nibble_writer_tb_pkg::ModeCommand);

    // random rounds, each with its own timing set
    for (r = 0; r < Rounds; r++) begin
      case (r)
        0: begin pulse = 16'h0000; data_wait = 16'h0000; cmd_wait = 16'h0000; end
        1: begin pulse = 16'hFFFF; data_wait = 16'hFFFF; cmd_wait = 16'hFFFF; end
        2: begin pulse = 16'h0001; data_wait = 16'h0000; cmd_wait = 16'hFFFF; end
        3: begin pulse = 16'hFFFF; data_wait = 16'h0001; cmd_wait = 16'h0000; end
        default: begin
          pulse = 16'($urandom);
          data_wait = 16'($urandom);
          cmd_wait = 16'($urandom);
        end
      endcase
      write_timing(pulse, data_wait, cmd_wait);
      for (i = 0; i < RoundItems; i++) begin
        if (i % 10 == 0) begin
          quiet_source = ($urandom_range(0, 3) == 0);
          quiet_sink <= ($urandom_range(0, 3) == 0);
        end
        send_request(pick_code(),
                     char_lcd_nibble_writer_tb_pkg::lcd_mode_t'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("** char_lcd_nibble_writer_core: PASSED **");
    end else begin
      $display("** char_lcd_nibble_writer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/clcd_nw_pkg.sv
src/clcd_nw_front.sv
src/clcd_nw_queue.sv
src/clcd_nw_back.sv
src/char_lcd_nibble_writer_core.sv
bench/char_lcd_nibble_writer_tb_pkg.sv
bench/char_lcd_nibble_writer_checker.sv
bench/char_lcd_nibble_writer_core_tb.sv
